// ===== sv/utfdec_pkg.sv =====
`default_nettype none

package utfdec_pkg;

    // Hard ceiling on the per-string unit budget.
    localparam int unsigned MAX_UNITS_LIMIT = 128;
    localparam logic [7:0]  MAX_UNITS_CAP   = 8'(MAX_UNITS_LIMIT);
    localparam logic [7:0]  MAX_UNITS_RESET = 8'd128;

    localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [7:0]  ASCII_TOP  = 8'h80;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_VAL   = 8'h80;
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_VAL  = 8'hE0;

    // Configuration register indexes (word address bit 2 and up).
    typedef enum logic
    {
        REG_MAX_UNITS = 1'b0,
        REG_UNUSED    = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [7:0] text_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed
    {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_last;
    } unit_item_t;

    // Results of one byte, handed from the decoder to the result buffer.
    typedef struct packed
    {
        logic [1:0]            cnt;
        unit_item_t [2:0]      slot;
    } burst_load_t;

    typedef struct packed
    {
        logic [2:0][15:0] units;
        logic [1:0]       nu;
        logic [1:0]       held_cnt;
        logic [1:0][7:0]  held;
    } decode_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_VAL;
    endfunction

    // Decodes the window formed by the held bytes and the new byte.
    // At most three steps are needed since the window holds three bytes.
    function automatic decode_t utf_decode(
        input logic [1:0] held,
        input logic [7:0] p0,
        input logic [7:0] p1,
        input logic [7:0] b,
        input logic       fin
    );
        logic [3:0][7:0] win;
        logic [1:0]      k;
        logic [1:0]      pos;
        logic [1:0]      pos1;
        logic [1:0]      pos2;
        logic [1:0]      avail;
        logic [1:0]      rest;
        logic            stop;
        logic            bad;
        logic [7:0]      c;
        logic [7:0]      n1;
        logic [7:0]      n2;
        decode_t         r;

        r    = '0;
        win  = '0;
        stop = 1'b0;
        pos  = 2'd0;
        unique case (held)
            2'd0:
            begin
                win[0] = b;
                k      = 2'd1;
            end
            2'd1:
            begin
                win[0] = p0;
                win[1] = b;
                k      = 2'd2;
            end
            default:
            begin
                win[0] = p0;
                win[1] = p1;
                win[2] = b;
                k      = 2'd3;
            end
        endcase

        for (int s = 0; s < 3; s++)
        begin
            if (!stop && (pos < k))
            begin
                c     = win[pos];
                avail = k - pos;
                pos1  = pos + 2'd1;
                pos2  = pos + 2'd2;
                n1    = win[pos1];
                n2    = win[pos2];
                bad   = ((avail >= 2'd2) && !is_cont(n1)) ||
                        ((avail == 2'd3) && !is_cont(n2));
                if (c < ASCII_TOP)
                begin
                    r.units[r.nu] = {8'h00, c};
                    r.nu          = r.nu + 2'd1;
                    pos           = pos + 2'd1;
                end
                else if ((c & LEAD2_MASK) == LEAD2_VAL)
                begin
                    if ((avail >= 2'd2) && is_cont(n1))
                    begin
                        r.units[r.nu] = {5'b0, c[4:0], n1[5:0]};
                        r.nu          = r.nu + 2'd1;
                        pos           = pos + 2'd2;
                    end
                    else if ((avail >= 2'd2) || fin)
                    begin
                        r.units[r.nu] = REPL_UNIT;
                        r.nu          = r.nu + 2'd1;
                        pos           = pos + 2'd1;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                else if ((c & LEAD3_MASK) == LEAD3_VAL)
                begin
                    if (bad || ((avail < 2'd3) && fin))
                    begin
                        r.units[r.nu] = REPL_UNIT;
                        r.nu          = r.nu + 2'd1;
                        pos           = pos + 2'd1;
                    end
                    else if (avail == 2'd3)
                    begin
                        r.units[r.nu] = {c[3:0], n1[5:0], n2[5:0]};
                        r.nu          = r.nu + 2'd1;
                        pos           = pos + 2'd3;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                else
                begin
                    r.units[r.nu] = REPL_UNIT;
                    r.nu          = r.nu + 2'd1;
                    pos           = pos + 2'd1;
                end
            end
        end

        rest       = k - pos;
        pos1       = pos + 2'd1;
        r.held[0]  = win[pos];
        r.held[1]  = win[pos1];
        r.held_cnt = (rest > 2'd2) ? 2'd2 : rest;
        if (fin)
        begin
            r.held_cnt = 2'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/utfdec_in_reg.sv =====
`default_nettype none

module utfdec_in_reg
    import utfdec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire byte_item_t byte_data,
    input  wire logic       take,
    output logic            item_valid,
    output byte_item_t      item
);

    logic       vld_reg;
    byte_item_t item_reg;

    // The register frees itself in the same cycle that the decoder takes it.
    assign byte_ready = !vld_reg || take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (take)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utfdec_core.sv =====
`default_nettype none

module utfdec_core
    import utfdec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire byte_item_t item,
    input  wire logic       burst_free,
    input  wire logic [7:0] max_units,
    output logic            take,
    output burst_load_t     load
);

    logic [1:0][7:0] pend_reg;
    logic [1:0]      pend_cnt_reg;
    logic [1:0]      pend_cnt_next;
    logic [7:0]      emitted_reg;
    logic [7:0]      emitted_next;
    decode_t         dec;
    logic [7:0]      cap;
    logic [7:0]      room;
    logic [1:0]      kept;
    logic [7:0]      total;
    logic            fin;

    assign take = item_valid && burst_free;
    assign fin  = item.final_byte;

    always_comb
    begin
        dec   = utf_decode(pend_cnt_reg, pend_reg[0], pend_reg[1], item.text_byte, fin);
        cap   = (max_units > MAX_UNITS_CAP) ? MAX_UNITS_CAP : max_units;
        room  = (cap > emitted_reg) ? (cap - emitted_reg) : 8'd0;
        kept  = (room < {6'b0, dec.nu}) ? room[1:0] : dec.nu;
        total = emitted_reg + {6'b0, kept};

        load.cnt = kept;
        for (int j = 0; j < 3; j++)
        begin
            load.slot[j].code_unit   = dec.units[j];
            load.slot[j].run_last    = (kept == 2'(j + 1));
            load.slot[j].string_last = (kept == 2'(j + 1)) && (fin || (total == cap));
        end

        emitted_next  = fin ? 8'd0 : total;
        pend_cnt_next = dec.held_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            emitted_reg  <= 8'd0;
        end
        else if (take)
        begin
            pend_cnt_reg <= pend_cnt_next;
            emitted_reg  <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_reg <= dec.held;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utfdec_burst.sv =====
`default_nettype none

module utfdec_burst
    import utfdec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load_en,
    input  wire burst_load_t load,
    output logic             burst_free,
    output logic             unit_valid,
    input  wire logic        unit_ready,
    output unit_item_t       unit_data
);

    unit_item_t [2:0] slot_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    assign pop        = (cnt_reg != 2'd0) && unit_ready;
    assign burst_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && unit_ready);
    assign unit_valid = (cnt_reg != 2'd0);
    assign unit_data  = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load_en)
        begin
            cnt_reg <= load.cnt;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            slot_reg <= load.slot;
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_to_ucs2_stream_decoder.sv =====
// Streaming UTF-8 to UCS-2 decoder. Bytes of a string arrive one request at a time on the
// byte channel, with final_byte marking the last byte; 16-bit code units leave on the unit
// channel. ASCII passes through, two- and three-byte sequences are decoded, and anything
// malformed (a stray continuation byte, a lead byte without its continuation bytes, a four-
// byte lead or an invalid byte) gives U+FFFD; after a broken lead the bytes behind it are
// decoded again, so one byte can give up to three units. run_last flags the last unit
// caused by a byte and string_last the last unit of a string. The max_units register (APB
// byte address 0, reset 128, saturated at 128, zero drops everything) caps the units of one
// string; further units are dropped while bytes are still consumed. A byte passes an input
// register and, once the result buffer can take it, is decoded into that buffer, which then
// offers its first unit. Throughput is one byte per cycle while each byte gives at most
// one unit and the unit channel is ready; a byte that gives more units keeps the decoder
// from taking the next byte until its last unit is leaving, since the three-entry result
// buffer drains one unit per cycle while the unit channel is ready. Change max_units only
// while no request is in flight.

`default_nettype none

module utf8_to_ucs2_stream_decoder
    import utfdec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire byte_item_t  byte_data,

    output logic             unit_valid,
    input  wire logic        unit_ready,
    output unit_item_t       unit_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        max_units_sel;
    logic [7:0]  max_units_val_reg;
    logic        cfg_wr;
    logic        item_valid;
    byte_item_t  item;
    logic        take;
    logic        burst_free;
    burst_load_t load;

    // Register writes complete in the access phase; there are no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Only the max_units register exists; other word addresses read as zero.
    assign max_units_sel = (paddr[2] == REG_MAX_UNITS);
    assign prdata        = max_units_sel ? {24'b0, max_units_val_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_val_reg <= MAX_UNITS_RESET;
        end
        else if (cfg_wr && max_units_sel)
        begin
            max_units_val_reg <= pwdata[7:0];
        end
    end

    // Input register: takes a new byte request while results are still draining.
    utfdec_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decoder: window of held bytes plus the new byte, unit budget, and held state.
    utfdec_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .burst_free (burst_free),
        .max_units  (max_units_val_reg),
        .take       (take),
        .load       (load)
    );

    // Result buffer: holds up to three units of one byte and shifts them out.
    utfdec_burst u_burst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (take),
        .load       (load),
        .burst_free (burst_free),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

endmodule

`default_nettype wire

// ===== sv/utfdec_checker.sv =====
`default_nettype none

module utfdec_checker
    import utfdec_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_ready,
    input wire logic        unit_valid,
    input wire logic        unit_ready,
    input wire unit_item_t  unit_data,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled unit stays offered with the same value.
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=> unit_valid && $stable(unit_data))
        else $error("unit request dropped or changed while stalled");

    // The byte channel only stalls while results are waiting to leave.
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> unit_valid)
        else $error("byte channel stalled with no unit pending");

    // A write to max_units reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_MAX_UNITS)
        |=> (paddr[2] != REG_MAX_UNITS) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("max_units readback mismatch");

    // The register is eight bits wide; the upper read bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:8] == 24'b0)
        else $error("upper read data bits set");

endmodule

bind utf8_to_ucs2_stream_decoder utfdec_checker u_utfdec_checker (.*);

`default_nettype wire

// ===== tb/utf8_to_ucs2_stream_decoder_tb.sv =====
`default_nettype none

module utf8_to_ucs2_stream_decoder_tb
    import utfdec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // A byte passes the input register before it is decoded into the result buffer, so
    // DRAIN_CYCLES quiet cycles are enough to be sure that a byte which gave no unit is done.
    localparam int DRAIN_CYCLES   = 8;
    // Cycles in a row with no request accepted on either channel before the run
    // is declared hung. The longest legal quiet stretch is a drain plus a
    // register write, plus a long run of receiver stalls.
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [2:0] MAX_UNITS_ADDR = {REG_MAX_UNITS, 2'b00};
    localparam logic [2:0] UNUSED_ADDR    = {REG_UNUSED, 2'b00};

    // Hand-picked bytes, each written as {text_byte, final_byte}.
    localparam logic [8:0] DIRECTED [25] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},                  // ASCII extremes
        {8'hC2, 1'b0}, {8'hA9, 1'b0},                  // two-byte sequence
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},   // three-byte sequence
        {8'h80, 1'b0},                                 // stray continuation
        {8'hF0, 1'b0}, {8'hFF, 1'b0},                  // four-byte lead, invalid
        {8'hC3, 1'b0}, {8'hC3, 1'b0}, {8'hA9, 1'b0},   // lead cut by another lead
        {8'hE2, 1'b0}, {8'h41, 1'b0},                  // early mismatch
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'h41, 1'b0},   // three units from one byte
        {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},   // largest three-byte value
        {8'hE2, 1'b0}, {8'h82, 1'b1},                  // string ends with bytes held
        {8'hC3, 1'b1},                                 // lone lead ends a string
        {8'h41, 1'b1}                                  // one-byte string
    };

    // Keeps its own copy of the decoder state and the unit budget, works out
    // the code units that each accepted byte should give, and checks the
    // units that leave the block against them in order.
    class ucs2_unit_tracker;
        unit_item_t  expected_units[$];
        logic [7:0]  held_bytes[2];
        int unsigned held_count;
        logic [7:0]  units_sent;
        logic [7:0]  unit_budget;
        int unsigned errors;

        function new();
            held_count  = 0;
            units_sent  = 8'd0;
            unit_budget = MAX_UNITS_RESET;
            errors      = 0;
        endfunction

        function void set_budget(logic [7:0] value);
            unit_budget = value;
        endfunction

        function bit is_cont_byte(logic [7:0] b);
            return (b & CONT_MASK) == CONT_VAL;
        endfunction

        function void note_byte(byte_item_t item);
            logic [7:0]  win[3];
            logic [15:0] units[3];
            unit_item_t  kept_units[3];
            int unsigned k;
            int unsigned pos;
            int unsigned nu;
            int unsigned avail;
            int unsigned kept;
            int unsigned cap;
            logic [7:0]  c;
            bit          fin;
            bit          bad;
            bit          stop;

            k    = 0;
            pos  = 0;
            nu   = 0;
            kept = 0;
            stop = 1'b0;
            fin  = item.final_byte;
            cap  = (unit_budget > MAX_UNITS_LIMIT) ? MAX_UNITS_LIMIT : unit_budget;

            for (int i = 0; i < held_count; i++)
            begin
                win[k] = held_bytes[i];
                k++;
            end
            win[k] = item.text_byte;
            k++;

            while (pos < k && !stop)
            begin
                c     = win[pos];
                avail = k - pos;
                if (c < ASCII_TOP)
                begin
                    units[nu] = {8'h00, c};
                    nu++;
                    pos += 1;
                end
                else if ((c & LEAD2_MASK) == LEAD2_VAL)
                begin
                    if (avail >= 2 && is_cont_byte(win[pos + 1]))
                    begin
                        units[nu] = {5'b0, c[4:0], win[pos + 1][5:0]};
                        nu++;
                        pos += 2;
                    end
                    else if (avail >= 2 || fin)
                    begin
                        units[nu] = REPL_UNIT;
                        nu++;
                        pos += 1;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                else if ((c & LEAD3_MASK) == LEAD3_VAL)
                begin
                    bad = (avail >= 2 && !is_cont_byte(win[pos + 1])) ||
                          (avail >= 3 && !is_cont_byte(win[pos + 2]));
                    if (bad || (avail < 3 && fin))
                    begin
                        units[nu] = REPL_UNIT;
                        nu++;
                        pos += 1;
                    end
                    else if (avail >= 3)
                    begin
                        units[nu] = {c[3:0], win[pos + 1][5:0], win[pos + 2][5:0]};
                        nu++;
                        pos += 3;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                else
                begin
                    units[nu] = REPL_UNIT;
                    nu++;
                    pos += 1;
                end
            end

            held_count = 0;
            while (pos < k && held_count < 2)
            begin
                held_bytes[held_count] = win[pos];
                held_count++;
                pos++;
            end
            if (fin)
            begin
                held_count = 0;
            end

            for (int i = 0; i < nu; i++)
            begin
                if (units_sent < cap)
                begin
                    units_sent++;
                    kept_units[kept].code_unit   = units[i];
                    kept_units[kept].run_last    = 1'b0;
                    kept_units[kept].string_last = (units_sent == cap);
                    kept++;
                end
            end
            if (kept > 0)
            begin
                kept_units[kept - 1].run_last = 1'b1;
                if (fin)
                begin
                    kept_units[kept - 1].string_last = 1'b1;
                end
            end
            for (int i = 0; i < kept; i++)
            begin
                expected_units.push_back(kept_units[i]);
            end
            if (fin)
            begin
                units_sent = 8'd0;
            end
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_unit(unit_item_t got);
            unit_item_t want;

            if (expected_units.size() == 0)
            begin
                report_mismatch("unexpected unit", got.code_unit, 16'h0000);
                return;
            end
            want = expected_units.pop_front();
            if (got.code_unit !== want.code_unit)
            begin
                report_mismatch("code_unit", got.code_unit, want.code_unit);
            end
            if (got.run_last !== want.run_last)
            begin
                report_mismatch("run_last", 16'(got.run_last), 16'(want.run_last));
            end
            if (got.string_last !== want.string_last)
            begin
                report_mismatch("string_last", 16'(got.string_last), 16'(want.string_last));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    byte_item_t  byte_data = '0;
    logic        unit_valid;
    logic        unit_ready = 1'b0;
    unit_item_t  unit_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ucs2_unit_tracker tracker;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               stall_cycles = 0;

    utf8_to_ucs2_stream_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver decides on every falling edge whether it will take a unit at
    // the next rising edge. The percentage is changed from phase to phase.
    always @(negedge clk)
    begin
        unit_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Both channels are sampled at the rising edge. Every accepted byte is
    // turned into expected units right away; every accepted unit is checked
    // against the oldest one waiting. The same block keeps the count of
    // cycles in which nothing moved, for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                tracker.note_byte(byte_data);
            end
            if (unit_valid && unit_ready)
            begin
                tracker.check_unit(unit_data);
            end
            if ((byte_valid && byte_ready) || (unit_valid && unit_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles = stall_cycles + 1;
            end
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("TIMEOUT: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one byte request and returns at the edge where it is accepted.
    // Before the byte goes out the sender may stay idle, as tx_idle_pct decides
    // at each falling edge. The valid line is assigned once per falling edge, so
    // a back-to-back byte simply keeps valid high with new data.
    task send_byte(input byte_item_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_data  = item;
        @(posedge clk);
        while (!byte_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering bytes and waits until every expected unit has come out,
    // then lets the pipeline settle so that a byte which gave no unit is done.
    task drain_units();
        @(negedge clk);
        byte_valid = 1'b0;
        while (tracker.expected_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write on the register port: setup, then access. The register
    // takes the value at the edge where the access phase sees pready.
    task reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (addr == MAX_UNITS_ADDR)
        begin
            tracker.set_budget(data[7:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Sends random strings until n_items bytes have gone out. Most characters
    // are well formed with random payload bits; the rest are random bytes and
    // sequences cut short. The phase may end in the middle of a string, which
    // leaves the string open across the next register write.
    task send_random_text(input int n_items, input bit pause_midway);
        logic [7:0] text[$];
        byte_item_t item;
        int         sent;
        int         nchars;
        int         pick;

        sent = 0;
        while (sent < n_items)
        begin
            text.delete();
            nchars = $urandom_range(1, 8);
            for (int c = 0; c < nchars; c++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    text.push_back(8'($urandom_range(0, 127)));
                end
                else if (pick < 65)
                begin
                    text.push_back(LEAD2_VAL | 8'($urandom_range(0, 31)));
                    text.push_back(CONT_VAL | 8'($urandom_range(0, 63)));
                end
                else if (pick < 85)
                begin
                    text.push_back(LEAD3_VAL | 8'($urandom_range(0, 15)));
                    text.push_back(CONT_VAL | 8'($urandom_range(0, 63)));
                    text.push_back(CONT_VAL | 8'($urandom_range(0, 63)));
                end
                else if (pick < 93)
                begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
                else if (pick < 96)
                begin
                    text.push_back(LEAD2_VAL | 8'($urandom_range(0, 31)));
                end
                else
                begin
                    text.push_back(LEAD3_VAL | 8'($urandom_range(0, 15)));
                    if (pick < 98)
                    begin
                        text.push_back(CONT_VAL | 8'($urandom_range(0, 63)));
                    end
                end
            end
            for (int i = 0; i < text.size() && sent < n_items; i++)
            begin
                item.text_byte  = text[i];
                item.final_byte = (i == text.size() - 1);
                send_byte(item);
                sent++;
                // Let the sender wait once for every unit to come out while
                // the receiver keeps stalling.
                if (pause_midway && sent == n_items / 2)
                begin
                    drain_units();
                end
            end
        end
    endtask

    initial
    begin
        byte_item_t item;

        tracker = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed bytes with the full budget, written explicitly.
        tx_idle_pct = 18;
        rx_idle_pct = 57;
        reg_write(MAX_UNITS_ADDR, 32'd128);
        for (int i = 0; i < 25; i++)
        begin
            send_byte(byte_item_t'(DIRECTED[i]));
        end

        // A tiny budget, so that most strings hit the limit and drop units.
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'd3);
        send_random_text(40, 1'b1);

        // A budget of zero drops every unit of every string.
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'd0);
        send_random_text(12, 1'b0);

        // The largest register value saturates to the hard ceiling. A write to
        // the unused address must leave the budget alone.
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'hFFFF_FFFF);
        reg_write(UNUSED_ADDR, 32'd5);
        tx_idle_pct = 57;
        rx_idle_pct = 18;
        send_random_text(40, 1'b0);
        // Leave a string open with several units already out.
        for (int i = 0; i < 4; i++)
        begin
            item.text_byte  = 8'($urandom_range(32, 126));
            item.final_byte = 1'b0;
            send_byte(item);
        end

        // Lower the budget below what the open string has already used, so the
        // rest of that string gives nothing.
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'd2);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_text(25, 1'b0);

        // Smallest nonzero budget, then a random one, at full rate.
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'd1);
        send_random_text(14, 1'b0);
        drain_units();
        reg_write(MAX_UNITS_ADDR, 32'($urandom_range(4, 127)));
        send_random_text(20, 1'b0);

        drain_units();
        if (tracker.errors == 0 && tracker.expected_units.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
